### hdl/cvc_pkg.sv
// ----------------------------------------------------------------------------
// CORDIC vectoring core package
// Shared types and fixed widths for the vectoring pipeline.
// ----------------------------------------------------------------------------
package cvc_pkg;

   localparam int FIELD_WIDTH       = 16;
   localparam int TABLE_INDEX_WIDTH = 4;

   typedef enum logic {
      KIND_LOAD    = 1'b0,
      KIND_COMPUTE = 1'b1
   } kind_type;

   typedef struct packed {
      logic     valid;
      kind_type kind;
   } ctrl_type;

   typedef struct packed {
      logic [TABLE_INDEX_WIDTH-1:0] index;
      logic signed [FIELD_WIDTH-1:0] value;
   } load_type;

endpackage

### hdl/cvc_stage.sv
// ----------------------------------------------------------------------------
// CORDIC vectoring stage
// One micro-rotation with its own angle table entry. A load word passing
// through updates the entry, so words keep their order against the table.
// ----------------------------------------------------------------------------
module cvc_stage #(
   parameter int STAGE      = 0,
   parameter int DATA_WIDTH = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  cvc_pkg::ctrl_type            ctrl_in,
   input  cvc_pkg::load_type            load_in,
   input  logic signed [DATA_WIDTH-1:0] x_in,
   input  logic signed [DATA_WIDTH-1:0] y_in,
   input  logic signed [DATA_WIDTH-1:0] z_in,
   output cvc_pkg::ctrl_type            ctrl_ff,
   output cvc_pkg::load_type            load_ff,
   output logic signed [DATA_WIDTH-1:0] x_ff,
   output logic signed [DATA_WIDTH-1:0] y_ff,
   output logic signed [DATA_WIDTH-1:0] z_ff
);
   import cvc_pkg::*;

   localparam logic [TABLE_INDEX_WIDTH-1:0] STAGE_INDEX = TABLE_INDEX_WIDTH'(STAGE);

   logic signed [FIELD_WIDTH-1:0] tab_ff;
   logic                          tab_wr;
   logic signed [DATA_WIDTH-1:0]  angle;
   logic signed [DATA_WIDTH-1:0]  dx;
   logic signed [DATA_WIDTH-1:0]  dy;
   logic                          positive;
   logic signed [DATA_WIDTH-1:0]  x_in_next;
   logic signed [DATA_WIDTH-1:0]  y_in_next;
   logic signed [DATA_WIDTH-1:0]  z_in_next;

   assign tab_wr   = ctrl_in.valid && (ctrl_in.kind == KIND_LOAD) &&
                     (load_in.index == STAGE_INDEX);
   assign angle    = DATA_WIDTH'(tab_ff);
   assign dx       = y_in >>> STAGE;
   assign dy       = x_in >>> STAGE;
   assign positive = !y_in[DATA_WIDTH-1] && (|y_in);

   always_comb begin
      if (positive) begin
         x_in_next = x_in + dx;
         y_in_next = y_in - dy;
         z_in_next = z_in + angle;
      end else begin
         x_in_next = x_in - dx;
         y_in_next = y_in + dy;
         z_in_next = z_in - angle;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tab_ff <= '0;
      end else if (tab_wr) begin
         tab_ff <= load_in.value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff <= '0;
      end else begin
         ctrl_ff <= ctrl_in;
      end
   end

   always_ff @(posedge clock) begin
      load_ff <= load_in;
      x_ff    <= x_in_next;
      y_ff    <= y_in_next;
      z_ff    <= z_in_next;
   end

   tab_write_only_on_load: assert property (@(posedge clock) disable iff (reset)
      !$stable(tab_ff) |-> $past(reset) || $past(tab_wr))
      else $error("angle entry changed without a matching load word");

endmodule

### hdl/cordic_vectoring_core_top.sv
// ----------------------------------------------------------------------------
// CORDIC vectoring core
// A word is taken every cycle; busy is never raised. Each compute word gives
// its result on rsp_strobe once it has passed one input register and one
// register stage per micro-rotation. Load words give no result and write the
// angle entry as they pass its stage, so a compute word always sees the table
// as of its own acceptance. The receiver cannot stall; results must be taken
// in the cycle they appear.
// ----------------------------------------------------------------------------
module cordic_vectoring_core_top #(
   parameter int ITERATIONS = 16,
   parameter int DATA_WIDTH = 16
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   start,
   output logic                                   busy,
   input  logic                                   req_kind,
   input  logic signed [cvc_pkg::FIELD_WIDTH-1:0] req_x_in,
   input  logic signed [cvc_pkg::FIELD_WIDTH-1:0] req_y_in,
   input  logic signed [cvc_pkg::FIELD_WIDTH-1:0] req_z_in,
   input  logic [cvc_pkg::TABLE_INDEX_WIDTH-1:0]  req_table_index,
   input  logic signed [cvc_pkg::FIELD_WIDTH-1:0] req_table_value,
   output logic                                   rsp_strobe,
   output logic signed [cvc_pkg::FIELD_WIDTH-1:0] rsp_x_out,
   output logic signed [cvc_pkg::FIELD_WIDTH-1:0] rsp_y_out,
   output logic signed [cvc_pkg::FIELD_WIDTH-1:0] rsp_z_out
);
   import cvc_pkg::*;

   logic                         accept;
   ctrl_type                     ctrl_in;
   load_type                     load_in;

   ctrl_type                     ctrl_ff [ITERATIONS+1];
   load_type                     load_ff [ITERATIONS+1];
   logic signed [DATA_WIDTH-1:0] x_ff    [ITERATIONS+1];
   logic signed [DATA_WIDTH-1:0] y_ff    [ITERATIONS+1];
   logic signed [DATA_WIDTH-1:0] z_ff    [ITERATIONS+1];

   assign busy   = 1'b0;
   assign accept = start && !busy;

   assign ctrl_in.valid = accept;
   assign ctrl_in.kind  = kind_type'(req_kind);
   assign load_in.index = req_table_index;
   assign load_in.value = req_table_value;

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff[0] <= '0;
      end else begin
         ctrl_ff[0] <= ctrl_in;
      end
   end

   always_ff @(posedge clock) begin
      load_ff[0] <= load_in;
      x_ff[0]    <= DATA_WIDTH'(req_x_in);
      y_ff[0]    <= DATA_WIDTH'(req_y_in);
      z_ff[0]    <= DATA_WIDTH'(req_z_in);
   end

   for (genvar i = 0; i < ITERATIONS; i++) begin : g_stage
      cvc_stage #(
         .STAGE      (i),
         .DATA_WIDTH (DATA_WIDTH)
      ) u_stage (
         .clock   (clock),
         .reset   (reset),
         .ctrl_in (ctrl_ff[i]),
         .load_in (load_ff[i]),
         .x_in    (x_ff[i]),
         .y_in    (y_ff[i]),
         .z_in    (z_ff[i]),
         .ctrl_ff (ctrl_ff[i+1]),
         .load_ff (load_ff[i+1]),
         .x_ff    (x_ff[i+1]),
         .y_ff    (y_ff[i+1]),
         .z_ff    (z_ff[i+1])
      );
   end

   assign rsp_strobe = ctrl_ff[ITERATIONS].valid &&
                       (ctrl_ff[ITERATIONS].kind == KIND_COMPUTE);
   assign rsp_x_out  = FIELD_WIDTH'(x_ff[ITERATIONS]);
   assign rsp_y_out  = FIELD_WIDTH'(y_ff[ITERATIONS]);
   assign rsp_z_out  = FIELD_WIDTH'(z_ff[ITERATIONS]);

   compute_gives_result: assert property (@(posedge clock) disable iff (reset)
      accept && (req_kind == KIND_COMPUTE) |-> ##(ITERATIONS+1) rsp_strobe)
      else $error("compute word lost in pipeline");

   load_gives_nothing: assert property (@(posedge clock) disable iff (reset)
      accept && (req_kind == KIND_LOAD) |-> ##(ITERATIONS+1) !rsp_strobe)
      else $error("load word produced a result");

   result_has_source: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(accept && (req_kind == KIND_COMPUTE), ITERATIONS+1))
      else $error("result without a matching compute word");

endmodule
